// ----- sv/plane_association_by_boundary_top_defines.svh -----
// ---------------------------------------------------------------------------
// Plane association assertion macros
// Shared macros for the concurrent checks of the plane association block.
// ---------------------------------------------------------------------------
`ifndef PLANE_ASSOCIATION_BY_BOUNDARY_TOP_DEFINES_SVH
`define PLANE_ASSOCIATION_BY_BOUNDARY_TOP_DEFINES_SVH

// check that is muted while reset is high
`define PAB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// check that also runs through reset
`define PAB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ----- sv/pab_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Plane association package
// Beat types, stage types and codes shared by the plane association block.
// ---------------------------------------------------------------------------
package pab_pkg;

   localparam int VAL_W     = 32;
   localparam int PROD_W    = 64;
   localparam int SUM_W     = 66;
   localparam int DIST_W    = 31;
   localparam int ANGLE_W   = 17;
   localparam int IDX_W     = 10;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 2;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_PLANE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NORMAL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POINT  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE = 2'd1;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic signed [VAL_W-1:0] val_x;
      logic signed [VAL_W-1:0] val_y;
      logic signed [VAL_W-1:0] val_z;
      logic signed [VAL_W-1:0] val_w;
      logic                    query_last;
   } req_type;

   typedef struct packed {
      logic              matched;
      logic [IDX_W-1:0]  match_index;
      logic [DIST_W-1:0] match_distance;
      logic              too_many;
   } rsp_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] b;
      logic signed [VAL_W-1:0] c;
      logic signed [VAL_W-1:0] d;
   } plane_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic                     query_last;
      logic signed [PROD_W-1:0] prod_x;
      logic signed [PROD_W-1:0] prod_y;
      logic signed [PROD_W-1:0] prod_z;
      logic signed [SUM_W-1:0]  offset;
   } prod_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              query_last;
      logic              gate_pass;
      logic [DIST_W-1:0] pt_dist;
   } score_type;

endpackage

// ----- sv/pab_prod.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Plane association product stage
// Three coefficient products and the scaled offset, registered.
// ---------------------------------------------------------------------------
module pab_prod #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  pab_pkg::req_type   in_item,
   input  pab_pkg::plane_type plane,
   output logic               out_valid,
   output pab_pkg::prod_type  out_item
);
   import pab_pkg::*;

   logic     valid_ff;
   prod_type item_ff;
   prod_type item_in;

   always_comb begin
      item_in.kind       = in_item.kind;
      item_in.query_last = in_item.query_last;
      item_in.prod_x     = plane.a * in_item.val_x;
      item_in.prod_y     = plane.b * in_item.val_y;
      item_in.prod_z     = plane.c * in_item.val_z;
      // d term only counts for boundary points
      if (in_item.kind == KIND_POINT) begin
         item_in.offset = SUM_W'(plane.d) <<< FRAC_BITS;
      end else begin
         item_in.offset = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- sv/pab_mag.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Plane association magnitude stage
// Sum, absolute value, angle gate and saturated distance, registered.
// ---------------------------------------------------------------------------
module pab_mag #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  pab_pkg::prod_type                   in_item,
   input  logic [pab_pkg::ANGLE_W-1:0]         angle_threshold,
   output logic                                out_valid,
   output pab_pkg::score_type                  out_item
);
   import pab_pkg::*;

   logic signed [SUM_W-1:0] sum;
   logic [SUM_W-1:0]        mag;
   logic [SUM_W-1:0]        angle_q;
   logic [SUM_W-1:0]        shifted;
   logic                    valid_ff;
   score_type               item_ff;
   score_type               item_in;

   always_comb begin
      sum = SUM_W'(in_item.prod_x) + SUM_W'(in_item.prod_y)
          + SUM_W'(in_item.prod_z) + in_item.offset;
      mag     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      angle_q = SUM_W'(angle_threshold) << FRAC_BITS;
      shifted = mag >> FRAC_BITS;

      item_in.kind       = in_item.kind;
      item_in.query_last = in_item.query_last;
      item_in.gate_pass  = mag > angle_q;
      if (|shifted[SUM_W-1:DIST_W]) begin
         item_in.pt_dist = '1;
      end else begin
         item_in.pt_dist = shifted[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- sv/pab_judge.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Plane association judge stage
// Query state, candidate scoring, best match tracking and result register.
// ---------------------------------------------------------------------------
module pab_judge #(
   parameter int MAX_MAP_PLANES = 1024,
   parameter int FRAC_BITS      = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  pab_pkg::score_type          in_item,
   input  logic [pab_pkg::DIST_W-1:0]  dist_threshold,
   input  logic                        rsp_stall,
   output logic                        hold,
   output logic                        rsp_valid,
   output pab_pkg::rsp_type            rsp_data
);
   import pab_pkg::*;

   localparam int CNT_W = $clog2(MAX_MAP_PLANES + 1);
   localparam logic [DIST_W-1:0] HUNDRED_Q = DIST_W'(64'd100 << FRAC_BITS);
   localparam logic [DIST_W-1:0] DIST_RESET =
      DIST_W'(((64'd1 << FRAC_BITS) * 64'd2 + 64'd5) / 64'd10);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MAP_PLANES);

   logic              gate_ff,  gate_in;
   logic [DIST_W-1:0] mind_ff,  mind_in;
   logic [DIST_W-1:0] best_ff,  best_in;
   logic [IDX_W-1:0]  bidx_ff,  bidx_in;
   logic              have_ff,  have_in;
   logic [CNT_W-1:0]  cnt_ff,   cnt_in;
   logic              ovf_ff,   ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff,  rsp_data_in;
   logic              fire;
   logic              emit;

   // result stage blocks only a last item while the held result is not taken
   assign hold = in_valid && in_item.query_last && rsp_valid_ff && rsp_stall;
   assign fire = in_valid && !hold;
   assign emit = fire && in_item.query_last;

   always_comb begin
      gate_in = gate_ff;
      mind_in = mind_ff;
      best_in = best_ff;
      bidx_in = bidx_ff;
      have_in = have_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      rsp_data_in = rsp_data_ff;

      if (fire) begin
         case (in_item.kind)
            KIND_PLANE: begin
               gate_in = 1'b0;
               mind_in = HUNDRED_Q;
               best_in = dist_threshold;
               bidx_in = '0;
               have_in = 1'b0;
               cnt_in  = '0;
               ovf_in  = 1'b0;
            end
            KIND_NORMAL: begin
               if (gate_in && (mind_in < best_in)) begin
                  best_in = mind_in;
                  bidx_in = IDX_W'(cnt_in - CNT_W'(1));
                  have_in = 1'b1;
               end
               gate_in = 1'b0;
               if (cnt_in >= CNT_MAX) begin
                  ovf_in = 1'b1;
               end else begin
                  cnt_in  = cnt_in + CNT_W'(1);
                  gate_in = in_item.gate_pass;
                  mind_in = HUNDRED_Q;
               end
            end
            KIND_POINT: begin
               if (gate_in && (in_item.pt_dist < mind_in)) begin
                  mind_in = in_item.pt_dist;
               end
            end
            default: begin
            end
         endcase

         if (in_item.query_last) begin
            if (gate_in && (mind_in < best_in)) begin
               best_in = mind_in;
               bidx_in = IDX_W'(cnt_in - CNT_W'(1));
               have_in = 1'b1;
            end
            rsp_data_in.matched        = have_in;
            rsp_data_in.match_index    = have_in ? bidx_in : '0;
            rsp_data_in.match_distance = have_in ? best_in : '0;
            rsp_data_in.too_many       = ovf_in;
            gate_in = 1'b0;
            mind_in = HUNDRED_Q;
            best_in = dist_threshold;
            bidx_in = '0;
            have_in = 1'b0;
            cnt_in  = '0;
            ovf_in  = 1'b0;
         end
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff      <= 1'b0;
         mind_ff      <= HUNDRED_Q;
         best_ff      <= DIST_RESET;
         bidx_ff      <= '0;
         have_ff      <= 1'b0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gate_ff      <= gate_in;
         mind_ff      <= mind_in;
         best_ff      <= best_in;
         bidx_ff      <= bidx_in;
         have_ff      <= have_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/plane_association_by_boundary_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Plane association by boundary points
// Matches one observed plane against a stream of candidate map planes.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : input beats. A kind-0 beat loads the observed plane (a,b,c,d) and
//            opens a query; a kind-1 beat opens a candidate with its normal;
//            kind-2 beats carry that candidate's boundary points. A beat with
//            query_last set closes the query and yields one rsp beat.
//   rsp_*  : one result beat per query: matched flag, winner index, winner
//            distance (Q format, saturated) and the too-many flag.
//   csr_*  : register writes, always ready. Index 0 is the distance gate,
//            index 1 the cosine gate. Write only while the block is idle.
// Timing:
//   One beat per cycle sustained while req_stall is low, set by the judge
//   stage folding one beat a cycle into the query state. Four register
//   stages: input, products, magnitude and judge/result, which drives rsp.
// Stall:
//   The pipeline moves as one. It halts (req_stall high) only when a
//   query_last beat reaches the judge stage while the previous result is
//   still held under rsp_stall; all other beats wait meanwhile.
// Reset:
//   Synchronous, active high. Clears all valids, the query state, the
//   observed plane, and restores both gate registers to their defaults.
// ---------------------------------------------------------------------------
module plane_association_by_boundary_top #(
   parameter int MAX_MAP_PLANES = 1024,
   parameter int FRAC_BITS      = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // input beats
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pab_pkg::req_type                 req_data,
   // result beats
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pab_pkg::rsp_type                 rsp_data,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pab_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pab_pkg::VAL_W-1:0]        csr_wdata
);
   import pab_pkg::*;

   // default gates: 0.2 for distance, 0.8 for cosine
   localparam logic [DIST_W-1:0] DIST_RESET =
      DIST_W'(((64'd1 << FRAC_BITS) * 64'd2 + 64'd5) / 64'd10);
   localparam logic [ANGLE_W-1:0] ANGLE_RESET =
      ANGLE_W'(((64'd1 << FRAC_BITS) * 64'd8 + 64'd5) / 64'd10);

   logic [DIST_W-1:0]  dist_thr_ff;
   logic [ANGLE_W-1:0] angle_thr_ff;
   logic               in_valid_ff;
   req_type            in_item_ff;
   plane_type          plane_ff;
   plane_type          plane_in;
   logic               adv;
   logic               hold;
   logic               prod_valid;
   prod_type           prod_item;
   logic               score_valid;
   score_type          score_item;

   // whole pipeline steps together unless the judge stage is blocked
   assign adv       = !hold;
   assign req_stall = hold;
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_thr_ff  <= DIST_RESET;
         angle_thr_ff <= ANGLE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DIST:  dist_thr_ff  <= csr_wdata[DIST_W-1:0];
            CSR_ANGLE: angle_thr_ff <= csr_wdata[ANGLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_item_ff <= req_data;
      end
   end

   // observed plane: taken as the plane beat leaves the input register, so
   // every later beat multiplies against it
   always_comb begin
      plane_in = plane_ff;
      if (adv && in_valid_ff && (in_item_ff.kind == KIND_PLANE)) begin
         plane_in.a = in_item_ff.val_x;
         plane_in.b = in_item_ff.val_y;
         plane_in.c = in_item_ff.val_z;
         plane_in.d = in_item_ff.val_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else begin
         plane_ff <= plane_in;
      end
   end

   pab_prod #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prod (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (in_valid_ff),
      .in_item   (in_item_ff),
      .plane     (plane_ff),
      .out_valid (prod_valid),
      .out_item  (prod_item)
   );

   pab_mag #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mag (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .in_valid        (prod_valid),
      .in_item         (prod_item),
      .angle_threshold (angle_thr_ff),
      .out_valid       (score_valid),
      .out_item        (score_item)
   );

   pab_judge #(
      .MAX_MAP_PLANES (MAX_MAP_PLANES),
      .FRAC_BITS      (FRAC_BITS)
   ) u_judge (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (score_valid),
      .in_item        (score_item),
      .dist_threshold (dist_thr_ff),
      .rsp_stall      (rsp_stall),
      .hold           (hold),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

endmodule

// ----- sv/pab_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Plane association port checker
// Port-level checks of the plane association block, bound to the top level.
// ---------------------------------------------------------------------------
`include "plane_association_by_boundary_top_defines.svh"

module pab_checker #(
   parameter int FRAC_BITS = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pab_pkg::rsp_type rsp_data
);
   import pab_pkg::*;

   localparam logic [DIST_W-1:0] HUNDRED_Q = DIST_W'(64'd100 << FRAC_BITS);

   `PAB_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   `PAB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "result dropped or changed under stall")

   `PAB_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "input stalled without a held result")

   `PAB_ASSERT(a_nomatch_zero, clock, reset, rsp_valid && !rsp_data.matched |-> rsp_data.match_index == 0 && rsp_data.match_distance == 0, "unmatched result carries index or distance")

   `PAB_ASSERT(a_match_bound, clock, reset, rsp_valid && rsp_data.matched |-> rsp_data.match_distance <= HUNDRED_Q, "winning distance above initial score")

endmodule

bind plane_association_by_boundary_top pab_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_pab_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
